// File: sv/mpqk_pkg.sv
// Package for the keyed min-priority queue: sizes, operation codes, slot word type.
// No dependencies; every other file imports it.
package mpqk_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_BITS = 16;

   localparam int FUNC_W  = 2;
   localparam int IKEY_W  = 16;
   localparam int VAL_W   = 32;
   localparam int TOTAL_W = 7;
   localparam int CMP_W   = 32;

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CTR_W  = $clog2(CAPACITY + 1);
   localparam int WORD_W = KEY_BITS + VAL_W;

   localparam logic [FUNC_W-1:0] FUNC_ADD = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DEQ = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_UPD = 2'd2;

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  addr;
      logic [WORD_W-1:0] data;
   } slot_wr_type;

endpackage

// File: sv/mpqk_slot_ram.sv
// Slot store of the queue: one key/value word per slot, one write, one registered read.
// Depends on mpqk_pkg.
module mpqk_slot_ram
   import mpqk_pkg::*;
(
   input  logic              clock,
   input  slot_wr_type       wr,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem_ff [CAPACITY];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/mpqk_cmp_unit.sv
// Shared comparator: equality for key search, signed less-than for the minimum search.
// Depends on mpqk_pkg.
module mpqk_cmp_unit
   import mpqk_pkg::*;
(
   input  logic [CMP_W-1:0] op_a,
   input  logic [CMP_W-1:0] op_b,
   output logic             eq,
   output logic             lt
);

   assign eq = (op_a == op_b);
   assign lt = ($signed(op_a) < $signed(op_b));

endmodule

// File: sv/min_priority_queue_keyed_unit.sv
// Top level of the keyed min-priority queue: sequencer, occupancy bits, result register.
// Depends on mpqk_pkg, mpqk_slot_ram, mpqk_cmp_unit.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  req     | in        | req_valid/req_ready  | req_func, req_item_key, req_item_value
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_out_valid, rsp_out_key, rsp_out_value,
//          |           |                      | rsp_dropped, rsp_is_empty, rsp_entry_total
//
// Every beat passes a scan, a commit and the idle state from accept to the next accept: the
// slot memory has one read port, so the scan issues one slot read a cycle, then the last
// read returns, a settle step ends the scan, the commit (held while the result register is
// busy) follows, and the idle state takes the next beat.
// Reset (synchronous) clears the occupancy bits and the count; the slot memory is not
// cleared, only slots marked used are ever consulted.
// A new request beat may be accepted while the previous result still waits; the commit of
// that request stalls until the result register is free.
module min_priority_queue_keyed_unit
   import mpqk_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [IKEY_W-1:0]   req_item_key,
   input  logic [VAL_W-1:0]    req_item_value,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_out_valid,
   output logic [IKEY_W-1:0]   rsp_out_key,
   output logic [VAL_W-1:0]    rsp_out_value,
   output logic                rsp_dropped,
   output logic                rsp_is_empty,
   output logic [TOTAL_W-1:0]  rsp_entry_total
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   // control
   logic [1:0]          state_ff, state_in;
   logic [CTR_W-1:0]    cnt_ff, cnt_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [CAPACITY-1:0] used_ff, used_in;
   logic [CTR_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                hit_fnd_ff, hit_fnd_in;
   logic                free_fnd_ff, free_fnd_in;
   logic                best_fnd_ff, best_fnd_in;

   // payload
   logic [FUNC_W-1:0]   op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [VAL_W-1:0]    val_ff, val_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                rd_used_ff, rd_used_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [KEY_BITS-1:0] best_key_ff, best_key_in;
   logic [VAL_W-1:0]    best_val_ff, best_val_in;
   logic                o_valid_ff, o_valid_in;
   logic [IKEY_W-1:0]   o_key_ff, o_key_in;
   logic [VAL_W-1:0]    o_val_ff, o_val_in;
   logic                o_drop_ff, o_drop_in;
   logic                o_empty_ff, o_empty_in;
   logic [TOTAL_W-1:0]  o_total_ff, o_total_in;

   // memory and compare unit
   slot_wr_type         wr;
   logic [IDX_W-1:0]    rd_addr;
   logic [WORD_W-1:0]   rd_data;
   logic [KEY_BITS-1:0] rd_key;
   logic [VAL_W-1:0]    rd_val;
   logic [CMP_W-1:0]    cmp_a, cmp_b;
   logic                cmp_eq, cmp_lt;

   logic                req_fire;
   logic                out_free;
   logic                issue;
   logic [CTR_W-1:0]    count_nx;

   mpqk_slot_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_key = rd_data[WORD_W-1:VAL_W];
   assign rd_val = rd_data[VAL_W-1:0];

   // one comparator serves both searches: key match or signed minimum
   always_comb begin
      if (op_ff == FUNC_DEQ) begin
         cmp_a = rd_val;
         cmp_b = best_val_ff;
      end else begin
         cmp_a = CMP_W'(rd_key);
         cmp_b = CMP_W'(key_ff);
      end
   end

   mpqk_cmp_unit u_cmp (
      .op_a (cmp_a),
      .op_b (cmp_b),
      .eq   (cmp_eq),
      .lt   (cmp_lt)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign issue     = (state_ff == ST_SCAN) && (cnt_ff < CTR_W'(CAPACITY));
   assign rd_addr   = cnt_ff[IDX_W-1:0];

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rd_vld_in    = issue;
      rd_idx_in    = cnt_ff[IDX_W-1:0];
      rd_used_in   = used_ff[cnt_ff[IDX_W-1:0]];
      used_in      = used_ff;
      count_in     = count_ff;
      count_nx     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      hit_fnd_in   = hit_fnd_ff;
      free_fnd_in  = free_fnd_ff;
      best_fnd_in  = best_fnd_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      hit_idx_in   = hit_idx_ff;
      free_idx_in  = free_idx_ff;
      best_idx_in  = best_idx_ff;
      best_key_in  = best_key_ff;
      best_val_in  = best_val_ff;
      o_valid_in   = o_valid_ff;
      o_key_in     = o_key_ff;
      o_val_in     = o_val_ff;
      o_drop_in    = o_drop_ff;
      o_empty_in   = o_empty_ff;
      o_total_in   = o_total_ff;
      wr.we        = 1'b0;
      wr.addr      = hit_idx_ff;
      wr.data      = {key_ff, val_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in       = req_func;
               key_in      = KEY_BITS'(req_item_key);
               val_in      = req_item_value;
               cnt_in      = '0;
               hit_fnd_in  = 1'b0;
               free_fnd_in = 1'b0;
               best_fnd_in = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               cnt_in = cnt_ff + CTR_W'(1);
            end
            // slot read last cycle is back: fold it into the searches
            if (rd_vld_ff) begin
               if (op_ff == FUNC_DEQ) begin
                  if (rd_used_ff && (!best_fnd_ff || cmp_lt)) begin
                     best_fnd_in = 1'b1;
                     best_idx_in = rd_idx_ff;
                     best_key_in = rd_key;
                     best_val_in = rd_val;
                  end
               end else begin
                  if (rd_used_ff && cmp_eq && !hit_fnd_ff) begin
                     hit_fnd_in = 1'b1;
                     hit_idx_in = rd_idx_ff;
                  end
                  if (!rd_used_ff && !free_fnd_ff) begin
                     free_fnd_in = 1'b1;
                     free_idx_in = rd_idx_ff;
                  end
               end
            end
            if (!issue && !rd_vld_ff) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               o_valid_in = 1'b0;
               o_key_in   = '0;
               o_val_in   = '0;
               o_drop_in  = 1'b0;
               case (op_ff)
                  FUNC_ADD: begin
                     if (hit_fnd_ff) begin
                        wr.we = 1'b1;
                     end else if (count_ff >= CTR_W'(CAPACITY) || !free_fnd_ff) begin
                        o_drop_in = 1'b1;
                     end else begin
                        wr.we                = 1'b1;
                        wr.addr              = free_idx_ff;
                        used_in[free_idx_ff] = 1'b1;
                        count_nx             = count_ff + CTR_W'(1);
                     end
                  end
                  FUNC_DEQ: begin
                     if (best_fnd_ff) begin
                        o_valid_in           = 1'b1;
                        o_key_in             = IKEY_W'(best_key_ff);
                        o_val_in             = best_val_ff;
                        used_in[best_idx_ff] = 1'b0;
                        count_nx             = count_ff - CTR_W'(1);
                     end
                  end
                  FUNC_UPD: begin
                     wr.we = hit_fnd_ff;
                  end
                  default: begin
                  end
               endcase
               count_in     = count_nx;
               o_empty_in   = (count_nx == '0);
               o_total_in   = TOTAL_W'(count_nx);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         used_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         hit_fnd_ff   <= 1'b0;
         free_fnd_ff  <= 1'b0;
         best_fnd_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_fnd_ff   <= hit_fnd_in;
         free_fnd_ff  <= free_fnd_in;
         best_fnd_ff  <= best_fnd_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      rd_idx_ff   <= rd_idx_in;
      rd_used_ff  <= rd_used_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      best_idx_ff <= best_idx_in;
      best_key_ff <= best_key_in;
      best_val_ff <= best_val_in;
      o_valid_ff  <= o_valid_in;
      o_key_ff    <= o_key_in;
      o_val_ff    <= o_val_in;
      o_drop_ff   <= o_drop_in;
      o_empty_ff  <= o_empty_in;
      o_total_ff  <= o_total_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_valid   = o_valid_ff;
   assign rsp_out_key     = o_key_ff;
   assign rsp_out_value   = o_val_ff;
   assign rsp_dropped     = o_drop_ff;
   assign rsp_is_empty    = o_empty_ff;
   assign rsp_entry_total = o_total_ff;

endmodule

// File: sv/mpqk_checker.sv
// Port-level checks for the keyed min-priority queue, bound to the top level.
// Depends on mpqk_pkg and min_priority_queue_keyed_unit.
module mpqk_checker
   import mpqk_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_out_valid,
   input logic [IKEY_W-1:0]  rsp_out_key,
   input logic [VAL_W-1:0]   rsp_out_value,
   input logic               rsp_dropped,
   input logic               rsp_is_empty
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_key) && $stable(rsp_out_value))
      else $error("result beat changed while stalled");

   // an accepted operation drops ready in the cycle after accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready again right after accept");

   // a drop is never reported with an empty store or with a dequeued entry
   a_drop_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> !rsp_is_empty && !rsp_out_valid)
      else $error("drop reported on empty store or with dequeued entry");

   // no dequeued entry means zero key and value
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> rsp_out_key == '0 && rsp_out_value == '0)
      else $error("nonzero entry fields without dequeue");

   // reset leaves no result pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind min_priority_queue_keyed_unit mpqk_checker u_mpqk_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_valid (rsp_out_valid),
   .rsp_out_key   (rsp_out_key),
   .rsp_out_value (rsp_out_value),
   .rsp_dropped   (rsp_dropped),
   .rsp_is_empty  (rsp_is_empty)
);
